// ----- rtl/mbfp_pkg.sv -----
// Package with the shared constants and state codes of the mipmap box filter pyramid.
`timescale 1ns / 1ps
package mbfp_pkg;
   localparam int MaxLogSize = 12;
   localparam int LineDepth  = 1 << MaxLogSize;
   localparam int LvlW       = $clog2(MaxLogSize + 1);
   localparam int AddrW      = MaxLogSize;
   localparam int CntW       = MaxLogSize;
   localparam int PosW       = 11;
   localparam int RspDataW   = 64;

   // Configuration register indexes.
   localparam logic CSR_LOG2_WIDTH  = 1'b0;
   localparam logic CSR_LOG2_HEIGHT = 1'b1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_STEP  = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   typedef logic [7:0] byte_type;
endpackage

// ----- rtl/mipmap_box_filter_pyramid.sv -----
// Top level of the streaming 2x2 box filter mipmap pyramid builder.
//
//  channel | direction | payload
//  req_    | in        | tdata: chan0, chan1, chan2, chan3
//  rsp_    | out       | tdata: level, column, row, avg0..avg3; tlast: last_of_step
//  csr_    | in        | we, index (0 width, 1 height), wdata
//
// An input word passes through an accept state, a step at the level where it stops,
// and a closing state that hands over the final result if there is one, plus a step
// and a wait state for every level it completes; the single-port line buffer read sets the per-level
// cost. Reset is synchronous and clears the counters and handshake state.
// A stalled result channel stops the sequencer when a result must move.
`timescale 1ns / 1ps
module mipmap_box_filter_pyramid import mbfp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // chan0, chan1, chan2, chan3
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // level, column, row, avg0..avg3, zero fill
   output logic                rsp_tlast,   // last_of_step
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [3:0]          csr_wdata
);
   logic [3:0]      log2_w_ff, log2_h_ff;
   logic [1:0]      state_ff, state_in;
   logic [LvlW-1:0] lv_ff, lv_in;
   logic [31:0]     pix_ff, pix_in;
   logic [35:0]     pair_ff, pair_in;
   logic [CntW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CntW-1:0] lcol_ff [MaxLogSize];
   logic [CntW-1:0] lrow_ff [MaxLogSize];
   logic [31:0]     held_ff [MaxLogSize];
   logic [35:0]     mem [LineDepth];
   logic [35:0]     rdata_ff;
   logic            pend_ff, pend_in;
   logic [57:0]     pend_data_ff, pend_data_in;
   logic            rsp_valid_ff, rsp_last_ff;
   logic [57:0]     rsp_data_ff;

   // Effective sizes and level count.
   logic [3:0] lw, lh, levels, shw, shh;
   logic [12:0] wfull, hfull;
   logic [CntW-1:0] wlast, hlast, cur_c, cur_r;
   logic [AddrW-1:0] addr;
   logic [35:0] pair_now;
   logic [31:0] held_now, avg;
   logic out_free, push, push_last, mem_wr, mem_rd, cnt_upd, held_wr;
   logic [3:0] lv_idx;

   assign lw     = (log2_w_ff > 4'(MaxLogSize)) ? 4'(MaxLogSize) : log2_w_ff;
   assign lh     = (log2_h_ff > 4'(MaxLogSize)) ? 4'(MaxLogSize) : log2_h_ff;
   assign levels = (lw < lh) ? lw : lh;
   assign lv_idx = 4'(lv_ff);
   assign shw    = lw - lv_idx;
   assign shh    = lh - lv_idx;
   assign wfull  = (13'd1 << shw) - 13'd1;
   assign hfull  = (13'd1 << shh) - 13'd1;
   assign wlast  = wfull[CntW-1:0];
   assign hlast  = hfull[CntW-1:0];
   assign cur_c  = lcol_ff[lv_idx];
   assign cur_r  = lrow_ff[lv_idx];
   assign held_now = held_ff[lv_idx];
   assign addr   = ~({AddrW{1'b1}} >> lv_idx) + AddrW'(cur_c[CntW-1:1]);

   // Per-channel pair sums and averages.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic [9:0] tot;
         pair_now[9*k +: 9] = {1'b0, held_now[8*k +: 8]} + {1'b0, pix_ff[8*k +: 8]};
         tot = {1'b0, rdata_ff[9*k +: 9]} + {1'b0, pair_ff[9*k +: 9]};
         avg[8*k +: 8] = tot[9:2];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      lv_in        = lv_ff;
      pix_in       = pix_ff;
      pair_in      = pair_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      push         = 1'b0;
      push_last    = 1'b0;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      cnt_upd      = 1'b0;
      held_wr      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pix_in   = req_tdata;
               lv_in    = '0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (lv_idx >= levels) begin
               state_in = ST_FLUSH;
            end else begin
               cnt_upd = 1'b1;
               col_in  = cur_c;
               row_in  = cur_r;
               pair_in = pair_now;
               if (!cur_c[0]) begin
                  held_wr  = 1'b1;
                  state_in = ST_FLUSH;
               end else if (!cur_r[0]) begin
                  mem_wr   = 1'b1;
                  state_in = ST_FLUSH;
               end else begin
                  mem_rd   = 1'b1;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            if (!pend_ff || out_free) begin
               push         = pend_ff;
               pend_in      = 1'b1;
               pend_data_in = {avg, PosW'(row_ff[CntW-1:1]), PosW'(col_ff[CntW-1:1]),
                               4'(lv_idx + 4'd1)};
               pix_in       = avg;
               lv_in        = lv_ff + LvlW'(1);
               state_in     = ST_STEP;
            end
         end
         ST_FLUSH: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               pend_in   = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         log2_w_ff    <= 4'd8;
         log2_h_ff    <= 4'd8;
         for (int i = 0; i < MaxLogSize; i++) begin
            lcol_ff[i] <= '0;
            lrow_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (push) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOG2_WIDTH:  log2_w_ff <= csr_wdata;
               CSR_LOG2_HEIGHT: log2_h_ff <= csr_wdata;
               default: ;
            endcase
            for (int i = 0; i < MaxLogSize; i++) begin
               lcol_ff[i] <= '0;
               lrow_ff[i] <= '0;
            end
         end else if (cnt_upd) begin
            if (cur_c == wlast) begin
               lcol_ff[lv_idx] <= '0;
               lrow_ff[lv_idx] <= (cur_r == hlast) ? '0 : cur_r + CntW'(1);
            end else begin
               lcol_ff[lv_idx] <= cur_c + CntW'(1);
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lv_ff        <= lv_in;
      pix_ff       <= pix_in;
      pair_ff      <= pair_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      pend_data_ff <= pend_data_in;
      if (held_wr) held_ff[lv_idx] <= pix_ff;
      if (push) begin
         rsp_data_ff <= pend_data_ff;
         rsp_last_ff <= push_last;
      end
   end

   // Line buffer of pair sums, one region per level.
   always_ff @(posedge clock) begin
      if (mem_wr) mem[addr] <= pair_now;
      if (mem_rd) rdata_ff <= mem[addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
endmodule

// ----- rtl/mbfp_checker.sv -----
// Port checker for the mipmap pyramid, bound to the top level.
`timescale 1ns / 1ps
module mbfp_checker import mbfp_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tlast
);
   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // After a word is taken the block is busy and not ready in the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on consecutive cycles");

   // Levels start at one.
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] != 4'd0)
      else $error("result with level zero");
endmodule

bind mipmap_box_filter_pyramid mbfp_checker u_mbfp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

// ----- test/mipmap_box_filter_pyramid_test.sv -----
// Self-checking testbench for the streaming 2x2 box filter mipmap pyramid builder.
`timescale 1ns / 1ps
module mipmap_box_filter_pyramid_test import mbfp_pkg::*; ();

   typedef struct packed {
      logic [3:0]  level;
      logic [10:0] column;
      logic [10:0] row;
      logic [7:0]  avg0;
      logic [7:0]  avg1;
      logic [7:0]  avg2;
      logic [7:0]  avg3;
      logic        last;
   } mip_pixel_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;   // chan0, chan1, chan2, chan3
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;   // level, column, row, avg0..avg3, zero fill
   logic                rsp_tlast;   // last_of_step
   logic                csr_we;
   logic                csr_index;
   logic [3:0]          csr_wdata;

   mipmap_box_filter_pyramid DUT (.*);

   // Shadow of the pyramid state.
   logic [3:0]  shadow_lw, shadow_lh;
   logic [35:0] line_sums [LineDepth];
   logic [7:0]  held_pixel [MaxLogSize][4];
   int unsigned col_cnt [MaxLogSize];
   int unsigned row_cnt [MaxLogSize];

   logic [31:0]    pending_pixels[$];
   mip_pixel_type  expected_pixels[$];
   int             errors = 0;
   int             words_sent = 0;
   int             words_seen = 0;
   int             hold_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic queue_pixel(input logic [31:0] px);
      pending_pixels.insert(pending_pixels.size(), px);
   endtask

   function automatic void clear_levels();
      for (int i = 0; i < MaxLogSize; i++) begin
         col_cnt[i] = 0;
         row_cnt[i] = 0;
      end
   endfunction

   // Feed one source pixel through the level chain, queueing every pixel it completes.
   function automatic void build_pyramid_step(input logic [31:0] word);
      int unsigned    lw, lh, levels, c, r, w, h, idx, above;
      logic [7:0]     pix [4];
      logic [8:0]     pair [4];
      mip_pixel_type  mp;
      int             made;
      lw = (shadow_lw > MaxLogSize) ? MaxLogSize : shadow_lw;
      lh = (shadow_lh > MaxLogSize) ? MaxLogSize : shadow_lh;
      levels = (lw < lh) ? lw : lh;
      made = 0;
      for (int k = 0; k < 4; k++) pix[k] = word[8*k +: 8];
      for (int lv = 0; lv < levels; lv++) begin
         c = col_cnt[lv];
         r = row_cnt[lv];
         w = 1 << (lw - lv);
         h = 1 << (lh - lv);
         if (c + 1 >= w) begin
            col_cnt[lv] = 0;
            row_cnt[lv] = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_cnt[lv] = c + 1;
         end
         if (c[0] == 1'b0) begin
            for (int k = 0; k < 4; k++) held_pixel[lv][k] = pix[k];
            break;
         end
         for (int k = 0; k < 4; k++) pair[k] = held_pixel[lv][k] + pix[k];
         idx = (LineDepth - (LineDepth >> lv) + (c >> 1)) % LineDepth;
         if (r[0] == 1'b0) begin
            line_sums[idx] = {pair[3], pair[2], pair[1], pair[0]};
            break;
         end
         for (int k = 0; k < 4; k++) begin
            above = line_sums[idx][9*k +: 9];
            pix[k] = 8'((above + pair[k]) >> 2);
         end
         mp.level  = 4'(lv + 1);
         mp.column = 11'(c >> 1);
         mp.row    = 11'(r >> 1);
         mp.avg0   = pix[0];
         mp.avg1   = pix[1];
         mp.avg2   = pix[2];
         mp.avg3   = pix[3];
         mp.last   = 1'b0;
         expected_pixels.insert(expected_pixels.size(), mp);
         made++;
      end
      if (made > 0) expected_pixels[expected_pixels.size() - 1].last = 1'b1;
   endfunction

   // Source driver: offers queued pixels, idling at random outside the calm stretch.
   always @(posedge clock) begin
      logic        nxt_valid;
      logic [31:0] nxt_data;
      logic        idle;
      nxt_valid = req_tvalid;
      nxt_data  = req_tdata;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            build_pyramid_step(req_tdata);
            words_sent++;
            nxt_valid = 1'b0;
         end
         idle = ($urandom_range(99) < 35) && !(words_sent >= 90 && words_sent < 150);
         if (!nxt_valid && pending_pixels.size() > 0 && !idle) begin
            nxt_valid = 1'b1;
            nxt_data  = pending_pixels.pop_front();
         end
      end
      req_tvalid <= nxt_valid;
      req_tdata  <= nxt_data;
   end

   // Result receiver: random stalls plus one long hold-off to back up the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else if (words_seen == 30 && rsp_tvalid && rsp_tready) begin
         hold_cycles <= 400;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 35) || (words_sent >= 90 && words_sent < 150);
      end
   end

   // Result checker: compares each accepted word with the oldest expected pixel.
   always @(posedge clock) begin
      mip_pixel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen <= words_seen + 1;
         got = {rsp_tdata[3:0], rsp_tdata[14:4], rsp_tdata[25:15], rsp_tdata[33:26],
                rsp_tdata[41:34], rsp_tdata[49:42], rsp_tdata[57:50], rsp_tlast};
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_tdata));
         end else begin
            want = expected_pixels.pop_front();
            if (got.level != want.level)
               report_mismatch($sformatf("level %0d want %0d", got.level, want.level));
            if (got.column != want.column)
               report_mismatch($sformatf("column %0d want %0d", got.column, want.column));
            if (got.row != want.row)
               report_mismatch($sformatf("row %0d want %0d", got.row, want.row));
            if (got.avg0 != want.avg0)
               report_mismatch($sformatf("avg0 %0d want %0d", got.avg0, want.avg0));
            if (got.avg1 != want.avg1)
               report_mismatch($sformatf("avg1 %0d want %0d", got.avg1, want.avg1));
            if (got.avg2 != want.avg2)
               report_mismatch($sformatf("avg2 %0d want %0d", got.avg2, want.avg2));
            if (got.avg3 != want.avg3)
               report_mismatch($sformatf("avg3 %0d want %0d", got.avg3, want.avg3));
            if (got.last != want.last)
               report_mismatch($sformatf("tlast %0b want %0b", got.last, want.last));
         end
      end
   end

   // Waits until every queued pixel is taken and every expected word has come back.
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [3:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_LOG2_WIDTH) shadow_lw = value;
      else shadow_lh = value;
      clear_levels();
   endtask

   task automatic run_phase(input logic [3:0] lw, input logic [3:0] lh, input int count);
      logic [31:0] px;
      wait_drained();
      write_csr(CSR_LOG2_WIDTH, lw);
      write_csr(CSR_LOG2_HEIGHT, lh);
      for (int i = 0; i < count; i++) begin
         px = $urandom();
         if ($urandom_range(9) == 0) px = '1;
         else if ($urandom_range(9) == 0) px = '0;
         queue_pixel(px);
      end
   endtask

   // Stimulus sequence.
   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_LOG2_WIDTH;
      csr_wdata = '0;
      shadow_lw = 4'd8;
      shadow_lh = 4'd8;
      clear_levels();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: 2x2 frames of saturated, empty and mixed pixels, then a one-pixel-wide column.
      write_csr(CSR_LOG2_WIDTH, 4'd1);
      write_csr(CSR_LOG2_HEIGHT, 4'd1);
      repeat (4) queue_pixel('1);
      repeat (4) queue_pixel('0);
      queue_pixel(32'hFF00_FF00);
      queue_pixel(32'h00FF_00FF);
      queue_pixel(32'hFFFF_0000);
      queue_pixel(32'h0000_FFFF);
      run_phase(4'd0, 4'd3, 6);

      // Random phases over small, skewed, deep and oversized images.
      run_phase(4'd2, 4'd2, 48);
      run_phase(4'd3, 4'd1, 40);
      run_phase(4'd1, 4'd3, 40);
      run_phase(4'd4, 4'd4, 32);
      run_phase(4'd15, 4'd15, 16);
      run_phase(4'd12, 4'd0, 6);
      run_phase(4'd2, 4'd5, 32);
      wait_drained();
      if (errors == 0) begin
         $display("PASS mipmap_box_filter_pyramid");
      end else begin
         $display("FAIL mipmap_box_filter_pyramid");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("FAIL mipmap_box_filter_pyramid");
      $finish;
   end
endmodule
